// ----- sv/tccw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared types and constants: command codes, classified operations, the
// command item passed from front to back, and the result item.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Command codes on the cmd input.
  localparam logic [1:0] CMD_PRINT_CUR = 2'd0;
  localparam logic [1:0] CMD_PRINT_AT  = 2'd1;
  localparam logic [1:0] CMD_MOVE      = 2'd2;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  // Configuration register indexes.
  localparam logic REG_FG_COLOR = 1'b0;
  localparam logic REG_BG_COLOR = 1'b1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam int         RESET_ROW    = 19;
  localparam logic [3:0] FG_RESET     = 4'd2;
  localparam logic [3:0] BG_RESET     = 4'd0;

  localparam int ADDR_W = 11;
  localparam int DATA_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  // Operation decided by the front end.
  typedef enum logic [2:0] {
    OP_PRINT_CUR,
    OP_NEWLINE,
    OP_PRINT_AT,
    OP_MOVE,
    OP_BAD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
  } item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [DATA_W-1:0] write_data;
    logic              status;
    logic [COL_W-1:0]  cur_col_out;
    logic [ROW_W-1:0]  cur_row_out;
  } result_t;

endpackage

// ----- sv/text_console_cell_writer.sv -----
`timescale 1ns / 1ps
// A pushed command waits in the command queue, is carried out by the back end,
// which updates the cursor and forms the cell address with one small multiply,
// and shows at the result ports (empty low). The back end takes one command per
// cycle while the result queue has room or is being drained.
// Reset (synchronous, active high): both queues empty, cursor at column 0 of
// row 19 modulo the row count, foreground colour 2, background colour 0.
// ----------------------------------------------------------------------------
// Text console cell writer
// Turns print and cursor commands into character cell writes for a text
// screen of COLUMNS by ROWS cells.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // Command side, queue style: a transfer happens when push is high and
  // full is low.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [7:0]  target_col,
  input  logic [7:0]  target_row,
  // Result side, queue style: the oldest result is shown while empty is
  // low and is transferred when pop is high.
  output logic        empty,
  input  logic        pop,
  output logic        write_valid,
  output logic [10:0] write_addr,
  output logic [15:0] write_data,
  output logic        status,
  output logic [6:0]  cur_col_out,
  output logic [4:0]  cur_row_out,
  // Configuration write channel. It is always ready; writes are meant to
  // happen only while the block is idle.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_data
);

  tccw_pkg::item_t   front_item;
  tccw_pkg::item_t   queue_head;
  tccw_pkg::result_t back_res;
  logic              queue_empty;
  logic              queue_pop;
  logic [3:0]        fg_colour;
  logic [3:0]        bg_colour;

  // Colour registers. Index 0 is the foreground colour, index 1 the
  // background colour.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_colour <= tccw_pkg::FG_RESET;
      bg_colour <= tccw_pkg::BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        tccw_pkg::REG_FG_COLOR: fg_colour <= cfg_data;
        tccw_pkg::REG_BG_COLOR: bg_colour <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end decodes the command and does the range check while the
  // command is being transferred in; the classified item goes straight
  // into the command queue.
  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .cmd        (cmd),
    .char_code  (char_code),
    .target_col (target_col),
    .target_row (target_row),
    .item       (front_item)
  );

  // The command queue lets the input side keep accepting while the back
  // end waits on a stalled result consumer.
  tccw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (full),
    .pop       (queue_pop),
    .head      (queue_head),
    .empty     (queue_empty)
  );

  // The back end owns the cursor and the result queue; it takes one command
  // from the queue in any cycle in which the result queue has room or is
  // being drained.
  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (queue_head),
    .head_empty (queue_empty),
    .head_pop   (queue_pop),
    .fg_colour  (fg_colour),
    .bg_colour  (bg_colour),
    .res        (back_res),
    .res_empty  (empty),
    .res_pop    (pop)
  );

  assign write_valid = back_res.write_valid;
  assign write_addr  = back_res.write_addr;
  assign write_data  = back_res.write_data;
  assign status      = back_res.status;
  assign cur_col_out = back_res.cur_col_out;
  assign cur_row_out = back_res.cur_row_out;

endmodule

// ----- sv/tccw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Classifies an incoming command into an operation, including the
// position range check, so the back end only has to carry it out.
// ----------------------------------------------------------------------------
module tccw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               [1:0] cmd,
  input  logic               [7:0] char_code,
  input  logic               [7:0] target_col,
  input  logic               [7:0] target_row,
  output tccw_pkg::item_t          item
);

  logic pos_ok;
  logic is_nl;

  assign pos_ok = ({1'b0, target_col} < 9'(COLUMNS)) && ({1'b0, target_row} < 9'(ROWS));
  assign is_nl  = (char_code == tccw_pkg::NEWLINE_CODE);

  always_comb begin
    item.ch  = char_code;
    item.col = target_col;
    item.row = target_row;
    unique case (cmd)
      tccw_pkg::CMD_PRINT_CUR: begin
        item.op = is_nl ? tccw_pkg::OP_NEWLINE : tccw_pkg::OP_PRINT_CUR;
      end
      tccw_pkg::CMD_PRINT_AT: begin
        if (!pos_ok) begin
          item.op = tccw_pkg::OP_BAD;
        end else if (is_nl) begin
          item.op = tccw_pkg::OP_NOP;
        end else begin
          item.op = tccw_pkg::OP_PRINT_AT;
        end
      end
      tccw_pkg::CMD_MOVE: begin
        item.op = pos_ok ? tccw_pkg::OP_MOVE : tccw_pkg::OP_BAD;
      end
      tccw_pkg::CMD_UNUSED: begin
        item.op = tccw_pkg::OP_NOP;
      end
      default: begin
        item.op = tccw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

// ----- sv/tccw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module tccw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tccw_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output tccw_pkg::item_t head,
  output logic            empty
);

  tccw_pkg::item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count out of range");
  a_ptr_spacing: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 2'd1))
    else $error("command queue count did not follow a push");

endmodule

// ----- sv/tccw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Holds the cursor and carries out one classified command a cycle while its
// two-entry result queue has room or is being drained; results go there.
// ----------------------------------------------------------------------------
module tccw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  tccw_pkg::item_t   head,
  input  logic              head_empty,
  output logic              head_pop,
  input  logic [3:0]        fg_colour,
  input  logic [3:0]        bg_colour,
  output tccw_pkg::result_t res,
  output logic              res_empty,
  input  logic              res_pop
);

  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int PW       = $clog2(ROWS * COLUMNS + 1);
  localparam int ResetRow = tccw_pkg::RESET_ROW % ROWS;

  logic [CW-1:0]     cursor_col;
  logic [RW-1:0]     cursor_row;
  logic [CW-1:0]     cursor_col_next;
  logic [RW-1:0]     cursor_row_next;
  logic [CW:0]       col_inc;
  logic [RW-1:0]     row_inc;
  logic [CW-1:0]     sel_col;
  logic [RW-1:0]     sel_row;
  logic [PW-1:0]     cell_index;
  tccw_pkg::result_t result;

  tccw_pkg::result_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_res_pop;

  assign res_empty  = (count == 2'd0);
  assign do_res_pop = res_pop && !res_empty;
  assign head_pop   = !head_empty && ((count != 2'd2) || do_res_pop);
  assign res        = slots[rd_ptr];

  assign col_inc = {1'b0, cursor_col} + (CW + 1)'(1);
  assign row_inc = (cursor_row == RW'(ROWS - 1)) ? '0 : cursor_row + RW'(1);

  assign sel_col    = (head.op == tccw_pkg::OP_PRINT_AT) ? CW'(head.col) : cursor_col;
  assign sel_row    = (head.op == tccw_pkg::OP_PRINT_AT) ? RW'(head.row) : cursor_row;
  assign cell_index = PW'(sel_row) * PW'(COLUMNS) + PW'(sel_col);

  always_comb begin
    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    result.write_valid = 1'b0;
    result.status      = 1'b0;
    unique case (head.op)
      tccw_pkg::OP_PRINT_CUR: begin
        result.write_valid = 1'b1;
        if (col_inc == (CW + 1)'(COLUMNS)) begin
          cursor_col_next = '0;
          cursor_row_next = row_inc;
        end else begin
          cursor_col_next = col_inc[CW-1:0];
        end
      end
      tccw_pkg::OP_NEWLINE: begin
        cursor_col_next = '0;
        cursor_row_next = row_inc;
      end
      tccw_pkg::OP_PRINT_AT: begin
        result.write_valid = 1'b1;
      end
      tccw_pkg::OP_MOVE: begin
        cursor_col_next = CW'(head.col);
        cursor_row_next = RW'(head.row);
      end
      tccw_pkg::OP_BAD: begin
        result.status = 1'b1;
      end
      tccw_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
    result.write_addr  = result.write_valid ? tccw_pkg::ADDR_W'(cell_index) : '0;
    result.write_data  = result.write_valid ? {bg_colour, fg_colour, head.ch} : '0;
    result.cur_col_out = tccw_pkg::COL_W'(cursor_col_next);
    result.cur_row_out = tccw_pkg::ROW_W'(cursor_row_next);
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      slots[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= RW'(ResetRow);
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      count      <= 2'd0;
    end else begin
      if (head_pop) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
        wr_ptr     <= ~wr_ptr;
      end
      if (do_res_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(head_pop) - 2'(do_res_pop);
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor_col} < (CW + 1)'(COLUMNS))
    else $error("cursor column beyond line length");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor_row} < (RW + 1)'(ROWS))
    else $error("cursor row beyond screen height");
  a_res_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result queue count out of range");
  a_hold_cursor: assert property (@(posedge clk) disable iff (rst)
    !head_pop |=> ($stable(cursor_col) && $stable(cursor_row)))
    else $error("cursor changed without a command");

endmodule

// ----- tb/text_console_cell_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell writer checker
// Watches the command, result and colour register channels. It predicts each
// result from its own cursor and colour state and compares it field by field.
// ----------------------------------------------------------------------------
module text_console_cell_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [7:0]  target_col,
  input  logic [7:0]  target_row,
  input  logic        empty,
  input  logic        pop,
  input  logic        write_valid,
  input  logic [10:0] write_addr,
  input  logic [15:0] write_data,
  input  logic        status,
  input  logic [6:0]  cur_col_out,
  input  logic [4:0]  cur_row_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          outstanding
);

  tccw_pkg::result_t awaited_results[$];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [3:0]        fg_colour;
  logic [3:0]        bg_colour;
  int                result_index;

  function automatic logic [15:0] cell_word(input logic [7:0] ch);
    return {bg_colour, fg_colour, ch};
  endfunction

  function automatic bit on_screen(input logic [7:0] col, input logic [7:0] row);
    return (int'(col) < COLUMNS) && (int'(row) < ROWS);
  endfunction

  // Applies one command to the cursor and returns the result it must produce.
  function automatic tccw_pkg::result_t next_console_result(input logic [1:0] c,
                                                            input logic [7:0] ch,
                                                            input logic [7:0] col,
                                                            input logic [7:0] row);
    tccw_pkg::result_t r;
    int unsigned       addr;
    r    = '0;
    addr = 0;
    case (c)
      tccw_pkg::CMD_PRINT_CUR: begin
        if (ch == tccw_pkg::NEWLINE_CODE) begin
          cur_col = 0;
          cur_row = (cur_row + 32'd1) % 32'(ROWS);
        end else begin
          addr          = cur_row * 32'(COLUMNS) + cur_col;
          r.write_valid = 1'b1;
          r.write_addr  = tccw_pkg::ADDR_W'(addr);
          r.write_data  = cell_word(ch);
          cur_col++;
          if (cur_col >= 32'(COLUMNS)) begin
            cur_col = 0;
            cur_row = (cur_row + 32'd1) % 32'(ROWS);
          end
        end
      end
      tccw_pkg::CMD_PRINT_AT: begin
        if (!on_screen(col, row)) begin
          r.status = 1'b1;
        end else if (ch != tccw_pkg::NEWLINE_CODE) begin
          addr          = 32'(row) * 32'(COLUMNS) + 32'(col);
          r.write_valid = 1'b1;
          r.write_addr  = tccw_pkg::ADDR_W'(addr);
          r.write_data  = cell_word(ch);
        end
      end
      tccw_pkg::CMD_MOVE: begin
        if (on_screen(col, row)) begin
          cur_col = 32'(col);
          cur_row = 32'(row);
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.cur_col_out = tccw_pkg::COL_W'(cur_col);
    r.cur_row_out = tccw_pkg::ROW_W'(cur_row);
    return r;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      if (fail_count < 10)
        $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
                 $realtime, result_index, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    tccw_pkg::result_t want;
    if (rst) begin
      awaited_results.delete();
      cur_col      = 0;
      cur_row      = 32'(tccw_pkg::RESET_ROW % ROWS);
      fg_colour    = tccw_pkg::FG_RESET;
      bg_colour    = tccw_pkg::BG_RESET;
      result_index = 0;
    end else begin
      // Commands pass the command queue before reaching the result queue, so a result
      // popped at this edge is always older than a command pushed at the same edge.
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result %0d arrived with nothing expected",
                     $realtime, result_index);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("write_valid", 32'(want.write_valid), 32'(write_valid));
          compare_field("write_addr", 32'(want.write_addr), 32'(write_addr));
          compare_field("write_data", 32'(want.write_data), 32'(write_data));
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("cur_col_out", 32'(want.cur_col_out), 32'(cur_col_out));
          compare_field("cur_row_out", 32'(want.cur_row_out), 32'(cur_row_out));
        end
        result_index++;
      end
      if (push && !full)
        awaited_results.push_back(next_console_result(cmd, char_code,
                                                      target_col, target_row));
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == tccw_pkg::REG_FG_COLOR)
          fg_colour = cfg_data;
        else
          bg_colour = cfg_data;
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell writer testbench
// Drives directed and random console commands through the block under
// several colour settings and idling patterns. A separate checker predicts
// every result; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int PHASES        = 5;
  // Cycles without any transfer before the run is declared hung. This is
  // generous by a wide margin even at the heaviest idling.
  localparam int STALL_LIMIT   = 2000;
  // Extra cycles allowed after the last result before touching the colour
  // registers or giving the verdict.
  localparam int SETTLE_CYCLES = 4;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        push       = 1'b0;
  logic        full;
  logic [1:0]  cmd        = tccw_pkg::CMD_PRINT_CUR;
  logic [7:0]  char_code  = '0;
  logic [7:0]  target_col = '0;
  logic [7:0]  target_row = '0;
  logic        empty;
  logic        pop        = 1'b0;
  logic        write_valid;
  logic [10:0] write_addr;
  logic [15:0] write_data;
  logic        status;
  logic [6:0]  cur_col_out;
  logic [4:0]  cur_row_out;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_addr   = tccw_pkg::REG_FG_COLOR;
  logic [3:0]  cfg_data   = '0;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  // Idling pattern per random phase: none, mostly idle sender, mostly
  // stalling receiver, light idling on both sides, and none again.
  int phase_send_idle[PHASES]  = '{0, 81, 0, 7, 0};
  int phase_recv_stall[PHASES] = '{0, 0, 81, 7, 0};

  text_console_cell_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .char_code  (char_code),
    .target_col (target_col),
    .target_row (target_row),
    .empty      (empty),
    .pop        (pop),
    .write_valid(write_valid),
    .write_addr (write_addr),
    .write_data (write_data),
    .status     (status),
    .cur_col_out(cur_col_out),
    .cur_row_out(cur_row_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  text_console_cell_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .char_code  (char_code),
    .target_col (target_col),
    .target_row (target_row),
    .empty      (empty),
    .pop        (pop),
    .write_valid(write_valid),
    .write_addr (write_addr),
    .write_data (write_data),
    .status     (status),
    .cur_col_out(cur_col_out),
    .cur_row_out(cur_row_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver decides afresh at every falling edge whether to take the
  // waiting result, so stalls fall on every phase of the block's work.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one command, possibly after some idle cycles, and holds it until
  // it is transferred. Returns at the falling edge after the transfer with push
  // still high, so the next command can follow without a gap.
  task automatic send_cmd(input logic [1:0] c, input logic [7:0] ch,
                          input logic [7:0] col, input logic [7:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    cmd        <= c;
    char_code  <= ch;
    target_col <= col;
    target_row <= row;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Mostly well-formed commands: printing at the cursor dominates so that the
  // cursor walks across line ends and wraps the screen; positions are mostly
  // on screen, with a share of arbitrary bytes that are usually off screen.
  task automatic send_random_cmd();
    logic [1:0] c;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
    int         pick;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    col  = 8'($urandom_range(COLUMNS - 1));
    row  = 8'($urandom_range(ROWS - 1));
    if ($urandom_range(99) < 20) begin
      col = 8'($urandom_range(255));
      row = 8'($urandom_range(255));
    end
    if (pick < 55) begin
      c = tccw_pkg::CMD_PRINT_CUR;
      if ($urandom_range(99) < 12)
        ch = tccw_pkg::NEWLINE_CODE;
    end else if (pick < 75) begin
      c = tccw_pkg::CMD_PRINT_AT;
      if ($urandom_range(99) < 5)
        ch = tccw_pkg::NEWLINE_CODE;
    end else if (pick < 95) begin
      c = tccw_pkg::CMD_MOVE;
    end else begin
      c = tccw_pkg::CMD_UNUSED;
    end
    send_cmd(c, ch, col, row);
  endtask

  // Drops push and waits until every expected result has been transferred
  // and the pipeline has had time to drain.
  task automatic settle();
    push <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_colour(input logic idx, input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with the colours left at their reset values. The cursor
    // starts at column 0 of row 19.
    send_cmd(tccw_pkg::CMD_PRINT_CUR, 8'h00, 8'h00, 8'h00);
    send_cmd(tccw_pkg::CMD_PRINT_CUR, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(tccw_pkg::CMD_PRINT_CUR, tccw_pkg::NEWLINE_CODE, 8'h00, 8'h00);
    // Bottom-right corner: printing there wraps both column and row.
    send_cmd(tccw_pkg::CMD_MOVE, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
    send_cmd(tccw_pkg::CMD_PRINT_CUR, 8'h41, 8'h00, 8'h00);
    // A newline on the last row wraps to the top.
    send_cmd(tccw_pkg::CMD_MOVE, 8'hFF, 8'(COLUMNS - 2), 8'(ROWS - 1));
    send_cmd(tccw_pkg::CMD_PRINT_CUR, tccw_pkg::NEWLINE_CODE, 8'hFF, 8'hFF);
    // A newline at the last column goes to the next row only once.
    send_cmd(tccw_pkg::CMD_MOVE, 8'h00, 8'(COLUMNS - 1), 8'd5);
    send_cmd(tccw_pkg::CMD_PRINT_CUR, tccw_pkg::NEWLINE_CODE, 8'h00, 8'h00);
    send_cmd(tccw_pkg::CMD_PRINT_CUR, 8'h80, 8'h00, 8'h00);
    // Moves just off screen and far off screen keep the cursor.
    send_cmd(tccw_pkg::CMD_MOVE, 8'h00, 8'(COLUMNS), 8'd0);
    send_cmd(tccw_pkg::CMD_MOVE, 8'h00, 8'd0, 8'(ROWS));
    send_cmd(tccw_pkg::CMD_MOVE, 8'h00, 8'hFF, 8'hFF);
    send_cmd(tccw_pkg::CMD_MOVE, 8'h00, 8'd0, 8'd0);
    // Printing at a position: both corners, both edges just off screen,
    // and newlines on and off screen.
    send_cmd(tccw_pkg::CMD_PRINT_AT, 8'h5A, 8'(COLUMNS - 1), 8'(ROWS - 1));
    send_cmd(tccw_pkg::CMD_PRINT_AT, 8'h7F, 8'd0, 8'd0);
    send_cmd(tccw_pkg::CMD_PRINT_AT, 8'h20, 8'(COLUMNS), 8'd3);
    send_cmd(tccw_pkg::CMD_PRINT_AT, 8'h20, 8'd5, 8'(ROWS));
    send_cmd(tccw_pkg::CMD_PRINT_AT, tccw_pkg::NEWLINE_CODE, 8'd10, 8'd10);
    send_cmd(tccw_pkg::CMD_PRINT_AT, tccw_pkg::NEWLINE_CODE, 8'hFF, 8'hFF);
    // The unused command changes nothing, whatever its fields hold.
    send_cmd(tccw_pkg::CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(tccw_pkg::CMD_UNUSED, 8'h00, 8'h00, 8'h00);
    send_cmd(tccw_pkg::CMD_PRINT_CUR, 8'h55, 8'h00, 8'h00);

    // Random part: each phase first sets the colours while the block is idle,
    // starting with both extremes and then mixed and random values.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_colour(tccw_pkg::REG_FG_COLOR, 4'hF);
          write_colour(tccw_pkg::REG_BG_COLOR, 4'hF);
        end
        1: begin
          write_colour(tccw_pkg::REG_FG_COLOR, 4'h0);
          write_colour(tccw_pkg::REG_BG_COLOR, 4'h0);
        end
        2: begin
          write_colour(tccw_pkg::REG_FG_COLOR, 4'($urandom_range(15)));
          write_colour(tccw_pkg::REG_BG_COLOR, 4'($urandom_range(15)));
        end
        3: begin
          write_colour(tccw_pkg::REG_FG_COLOR, 4'hF);
          write_colour(tccw_pkg::REG_BG_COLOR, 4'h0);
        end
        default: begin
          write_colour(tccw_pkg::REG_FG_COLOR, 4'h0);
          write_colour(tccw_pkg::REG_BG_COLOR, 4'hF);
        end
      endcase
      send_idle_pct  = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      repeat (RANDOM_ITEMS / PHASES) send_random_cmd();
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
